FILE: sv/tea_pkg.sv
// Shared types and constants of the TEA block cipher unit.
`default_nettype none

package tea_pkg;

    localparam int ROUNDS = 32;
    localparam int CELLS  = 2 * ROUNDS;

    localparam int WORD_W = 32;
    localparam int CFG_IDX_W = 3;

    localparam logic [WORD_W-1:0] DELTA = 32'h9e3779b9;
    localparam logic [WORD_W-1:0] SUM_DEC = WORD_W'(64'(DELTA) * 64'(ROUNDS));

    localparam logic [CFG_IDX_W-1:0] CFG_KEY0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY3 = 3'd3;

    localparam logic REQ_ENCRYPT = 1'b0;
    localparam logic REQ_DECRYPT = 1'b1;

    typedef struct packed {
        logic              req_type;
        logic [WORD_W-1:0] block_left;
        logic [WORD_W-1:0] block_right;
    } t_in_beat;

    typedef struct packed {
        logic [WORD_W-1:0] out_left;
        logic [WORD_W-1:0] out_right;
    } t_out_beat;

    typedef struct packed {
        logic [WORD_W-1:0] k0;
        logic [WORD_W-1:0] k1;
        logic [WORD_W-1:0] k2;
        logic [WORD_W-1:0] k3;
    } t_key;

    // The word x is mixed into y, then the two trade places.
    typedef struct packed {
        logic              dec;
        logic              phase;
        logic [WORD_W-1:0] x;
        logic [WORD_W-1:0] y;
        logic [WORD_W-1:0] sum;
    } t_cell;

endpackage

`default_nettype wire

FILE: sv/tea_cell.sv
// One half-round cell of the TEA pipeline with its own register and flow control.
`default_nettype none

module tea_cell (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire tea_pkg::t_key  i_key,
    input  wire                 i_valid,
    input  wire tea_pkg::t_cell i_data,
    output logic                o_ready,
    output logic                o_valid,
    output tea_pkg::t_cell      o_data,
    input  wire                 i_ready
);

    logic                       r_valid;
    tea_pkg::t_cell             r_data;
    tea_pkg::t_cell             n_data;
    logic                       take;
    logic                       use01;
    logic [tea_pkg::WORD_W-1:0] ka;
    logic [tea_pkg::WORD_W-1:0] kb;
    logic [tea_pkg::WORD_W-1:0] w;
    logic [tea_pkg::WORD_W-1:0] mix;

    assign o_ready = !r_valid || i_ready;
    assign take    = i_valid && o_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_comb begin
        w     = i_data.x;
        use01 = (i_data.phase == i_data.dec);
        ka    = use01 ? i_key.k0 : i_key.k2;
        kb    = use01 ? i_key.k1 : i_key.k3;
        mix   = ((w << 4) + ka) ^ (w + i_data.sum) ^ ((w >> 5) + kb);

        n_data.dec   = i_data.dec;
        n_data.phase = !i_data.phase;
        n_data.y     = w;
        if (i_data.dec == tea_pkg::REQ_DECRYPT) begin
            n_data.x = i_data.y - mix;
        end else begin
            n_data.x = i_data.y + mix;
        end
        if (!i_data.phase) begin
            n_data.sum = i_data.sum;
        end else if (i_data.dec == tea_pkg::REQ_DECRYPT) begin
            n_data.sum = i_data.sum - tea_pkg::DELTA;
        end else begin
            n_data.sum = i_data.sum + tea_pkg::DELTA;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_data <= n_data;
        end
    end

    a_phase_toggles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take |=> r_data.phase != $past(i_data.phase))
        else $error("cell phase did not toggle");

    a_dec_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take |=> r_data.dec == $past(i_data.dec))
        else $error("cell lost the request type");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && !i_ready |=> r_valid && $stable(r_data))
        else $error("cell changed a held beat");

    a_sum_fixed_first_half: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take && !i_data.phase |=> r_data.sum == $past(i_data.sum))
        else $error("sum changed in the first half of a round");

endmodule

`default_nettype wire

FILE: sv/tea_block_cipher_unit.sv
// Top level of the TEA block cipher unit: key registers and the chain of round cells.
//
// Input beats carry a request type (encrypt or decrypt) and a 64-bit block as
// two 32-bit words; each input beat yields exactly one output beat with the
// transformed words, in the same order.
// The 128-bit key is written through the plain write port as four words at
// indexes 0 to 3; writes to other indexes are ignored. The user must write keys
// only while the unit is empty; the unit itself does not enforce this.
// The datapath is a row of 2*ROUNDS half-round cells, 64 at the default of 32
// rounds, each with its own register. A block accepted into the first cell
// passes through every cell's register in turn before it is shown on the
// output; one block can be accepted in every cycle while the output is not stalled.
// Each cell moves its beat on whenever its neighbor downstream is empty or
// moving, so bubbles close up and the unit keeps accepting while the last cell
// holds a finished beat. When the receiver stalls, beats pile up behind the
// output until all cells are full, and only then is the input stalled.
// Reset empties every cell and clears the key to zero.
`default_nettype none

module tea_block_cipher_unit (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_cfg_we,
    input  wire  [tea_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire  [tea_pkg::WORD_W-1:0]        i_cfg_data,
    input  wire                               i_in_valid,
    output logic                              o_in_stall,
    input  wire  tea_pkg::t_in_beat           i_in_data,
    output logic                              o_out_valid,
    input  wire                               i_out_stall,
    output tea_pkg::t_out_beat                o_out_data
);

    tea_pkg::t_key  r_key;
    tea_pkg::t_cell w_data  [tea_pkg::CELLS+1];
    logic           w_valid [tea_pkg::CELLS+1];
    logic           w_ready [tea_pkg::CELLS+1];
    tea_pkg::t_cell last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                tea_pkg::CFG_KEY0: r_key.k0 <= i_cfg_data;
                tea_pkg::CFG_KEY1: r_key.k1 <= i_cfg_data;
                tea_pkg::CFG_KEY2: r_key.k2 <= i_cfg_data;
                tea_pkg::CFG_KEY3: r_key.k3 <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        w_data[0].dec   = i_in_data.req_type;
        w_data[0].phase = 1'b0;
        if (i_in_data.req_type == tea_pkg::REQ_DECRYPT) begin
            w_data[0].x   = i_in_data.block_left;
            w_data[0].y   = i_in_data.block_right;
            w_data[0].sum = tea_pkg::SUM_DEC;
        end else begin
            w_data[0].x   = i_in_data.block_right;
            w_data[0].y   = i_in_data.block_left;
            w_data[0].sum = tea_pkg::DELTA;
        end
    end

    assign w_valid[0] = i_in_valid;
    assign o_in_stall = !w_ready[0];
    assign w_ready[tea_pkg::CELLS] = !i_out_stall;

    for (genvar g = 0; g < tea_pkg::CELLS; g++) begin : g_cell
        tea_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_key   (r_key),
            .i_valid (w_valid[g]),
            .i_data  (w_data[g]),
            .o_ready (w_ready[g]),
            .o_valid (w_valid[g+1]),
            .o_data  (w_data[g+1]),
            .i_ready (w_ready[g+1])
        );
    end

    assign last        = w_data[tea_pkg::CELLS];
    assign o_out_valid = w_valid[tea_pkg::CELLS];

    always_comb begin
        if (last.dec == tea_pkg::REQ_DECRYPT) begin
            o_out_data.out_left  = last.x;
            o_out_data.out_right = last.y;
        end else begin
            o_out_data.out_left  = last.y;
            o_out_data.out_right = last.x;
        end
    end

endmodule

`default_nettype wire

FILE: sim/tb_tea_block_cipher_unit.sv
// Self-checking testbench for the TEA block cipher unit with a cycle-free predictor.
`default_nettype none

module tb_tea_block_cipher_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int BLOCKS_PER_PHASE = 105;
    localparam int PHASES = 6;
    localparam int TAIL_CYCLES = 2 * tea_pkg::CELLS + 16;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic [tea_pkg::CFG_IDX_W-1:0] i_cfg_idx;
    logic [tea_pkg::WORD_W-1:0] i_cfg_data;
    logic i_in_valid;
    logic o_in_stall;
    tea_pkg::t_in_beat i_in_data;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    tea_pkg::t_out_beat o_out_data;

    tea_pkg::t_key key_model;
    tea_pkg::t_out_beat expected_blocks[$];
    int err_count = 0;
    int in_idle_pct = 0;
    int out_stall_pct = 0;

    tea_pkg::t_in_beat directed_blocks [0:11] = '{
        {tea_pkg::REQ_ENCRYPT, 32'h0000_0000, 32'h0000_0000},
        {tea_pkg::REQ_ENCRYPT, 32'hffff_ffff, 32'hffff_ffff},
        {tea_pkg::REQ_ENCRYPT, 32'h0000_0000, 32'hffff_ffff},
        {tea_pkg::REQ_ENCRYPT, 32'hffff_ffff, 32'h0000_0000},
        {tea_pkg::REQ_ENCRYPT, 32'haaaa_aaaa, 32'h5555_5555},
        {tea_pkg::REQ_ENCRYPT, 32'h8000_0000, 32'h0000_0001},
        {tea_pkg::REQ_DECRYPT, 32'h0000_0000, 32'h0000_0000},
        {tea_pkg::REQ_DECRYPT, 32'hffff_ffff, 32'hffff_ffff},
        {tea_pkg::REQ_DECRYPT, 32'h0000_0000, 32'hffff_ffff},
        {tea_pkg::REQ_DECRYPT, 32'hffff_ffff, 32'h0000_0000},
        {tea_pkg::REQ_DECRYPT, 32'h5555_5555, 32'haaaa_aaaa},
        {tea_pkg::REQ_DECRYPT, 32'h0000_0001, 32'h8000_0000}
    };

    tea_block_cipher_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic [tea_pkg::WORD_W-1:0] feistel_mix(
        input logic [tea_pkg::WORD_W-1:0] w,
        input logic [tea_pkg::WORD_W-1:0] s,
        input logic [tea_pkg::WORD_W-1:0] ka,
        input logic [tea_pkg::WORD_W-1:0] kb);
        return ((w << 4) + ka) ^ (w + s) ^ ((w >> 5) + kb);
    endfunction

    function automatic tea_pkg::t_out_beat tea_transform(input tea_pkg::t_in_beat b,
                                                         input tea_pkg::t_key k);
        logic [tea_pkg::WORD_W-1:0] l;
        logic [tea_pkg::WORD_W-1:0] r;
        logic [tea_pkg::WORD_W-1:0] s;
        tea_pkg::t_out_beat res;
        l = b.block_left;
        r = b.block_right;
        if (b.req_type == tea_pkg::REQ_ENCRYPT) begin
            s = '0;
            for (int n = 0; n < tea_pkg::ROUNDS; n++) begin
                s = s + tea_pkg::DELTA;
                l = l + feistel_mix(r, s, k.k0, k.k1);
                r = r + feistel_mix(l, s, k.k2, k.k3);
            end
        end else begin
            s = tea_pkg::DELTA * tea_pkg::ROUNDS;
            for (int n = 0; n < tea_pkg::ROUNDS; n++) begin
                r = r - feistel_mix(l, s, k.k2, k.k3);
                l = l - feistel_mix(r, s, k.k0, k.k1);
                s = s - tea_pkg::DELTA;
            end
        end
        res.out_left = l;
        res.out_right = r;
        return res;
    endfunction

    function automatic logic [tea_pkg::WORD_W-1:0] pick_word();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            default: return $urandom;
        endcase
    endfunction

    task automatic report_mismatch(input string what,
                                   input logic [tea_pkg::WORD_W-1:0] got,
                                   input logic [tea_pkg::WORD_W-1:0] want);
        $display("%0t: mismatch in %s: got %h, expected %h", $time, what, got, want);
        err_count++;
    endtask

    task automatic push_block(input tea_pkg::t_in_beat b);
        while ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= b;
        do @(posedge i_clk); while (o_in_stall);
        expected_blocks.push_back(tea_transform(b, key_model));
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (expected_blocks.size() != 0);
    endtask

    // The out-of-range write goes last so that an index alias would clobber a key word.
    task automatic load_key(input tea_pkg::t_key k);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= tea_pkg::CFG_KEY0;
        i_cfg_data <= k.k0;
        @(posedge i_clk);
        i_cfg_idx <= tea_pkg::CFG_KEY1;
        i_cfg_data <= k.k1;
        @(posedge i_clk);
        i_cfg_idx <= tea_pkg::CFG_KEY2;
        i_cfg_data <= k.k2;
        @(posedge i_clk);
        i_cfg_idx <= tea_pkg::CFG_KEY3;
        i_cfg_data <= k.k3;
        @(posedge i_clk);
        i_cfg_idx <= tea_pkg::CFG_IDX_W'($urandom_range(int'(tea_pkg::CFG_KEY3) + 1,
                                                        (1 << tea_pkg::CFG_IDX_W) - 1));
        i_cfg_data <= $urandom;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        key_model = k;
    endtask

    task automatic set_idle_mode(input int mode);
        case (mode)
            0: begin
                in_idle_pct = 19;
                out_stall_pct = 72;
            end
            1: begin
                in_idle_pct = 72;
                out_stall_pct = 19;
            end
            default: begin
                in_idle_pct = 0;
                out_stall_pct = 0;
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < out_stall_pct);
    end

    always @(posedge i_clk) begin
        tea_pkg::t_out_beat want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_blocks.size() == 0) begin
                report_mismatch("unexpected beat", o_out_data.out_left, '0);
            end else begin
                want = expected_blocks.pop_front();
                if (o_out_data.out_left !== want.out_left)
                    report_mismatch("out_left", o_out_data.out_left, want.out_left);
                if (o_out_data.out_right !== want.out_right)
                    report_mismatch("out_right", o_out_data.out_right, want.out_right);
            end
        end
    end

    initial begin
        tea_pkg::t_key k;
        tea_pkg::t_in_beat b;
        tea_pkg::t_out_beat last_cipher;
        logic have_cipher;
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_idx <= '0;
        i_cfg_data <= '0;
        i_in_valid <= 1'b0;
        i_in_data <= '0;
        key_model = '0;
        set_idle_mode(0);
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_blocks[i]) push_block(directed_blocks[i]);
        drain();
        load_key('1);
        foreach (directed_blocks[i]) push_block(directed_blocks[i]);

        for (int phase = 0; phase < PHASES; phase++) begin
            drain();
            set_idle_mode(phase / 2);
            case (phase)
                1: k = {32'h8000_0000, 32'h0000_0001, 32'h8000_0000, 32'h0000_0001};
                3: k = '0;
                5: k = '1;
                default: k = {$urandom, $urandom, $urandom, $urandom};
            endcase
            load_key(k);
            have_cipher = 1'b0;
            for (int n = 0; n < BLOCKS_PER_PHASE; n++) begin
                if (phase == 2 && n == BLOCKS_PER_PHASE / 2)
                    drain();
                if (have_cipher && $urandom_range(3) == 0) begin
                    b = {tea_pkg::REQ_DECRYPT, last_cipher.out_left, last_cipher.out_right};
                end else begin
                    b.req_type = $urandom_range(1) ? tea_pkg::REQ_DECRYPT
                                                   : tea_pkg::REQ_ENCRYPT;
                    b.block_left = pick_word();
                    b.block_right = pick_word();
                end
                push_block(b);
                if (b.req_type == tea_pkg::REQ_ENCRYPT) begin
                    last_cipher = tea_transform(b, key_model);
                    have_cipher = 1'b1;
                end
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (expected_blocks.size() != 0)
            report_mismatch("missing beats", '0, expected_blocks.size());
        if (err_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #2ms;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire
